/* hdl/polyphonic_wavetable_synth_macros.svh */
// Assertion macros for the polyphonic wavetable synthesizer.
// Used by the top level only; no other dependencies.
`ifndef POLYPHONIC_WAVETABLE_SYNTH_MACROS_SVH
`define POLYPHONIC_WAVETABLE_SYNTH_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PWS_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define PWS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* hdl/pws_pkg.sv */
// Package for the polyphonic wavetable synthesizer.
// Holds command codes, register indexes and the voice record type.
`timescale 1ns / 1ps
package pws_pkg;
	localparam logic [2:0] CMD_NOTE_ON   = 3'd0;
	localparam logic [2:0] CMD_SAMPLE    = 3'd1;
	localparam logic [2:0] CMD_ENV       = 3'd2;
	localparam logic [2:0] CMD_LOAD_WAVE = 3'd3;
	localparam logic [2:0] CMD_LOAD_ENV  = 3'd4;
	localparam logic [2:0] CMD_LOAD_STEP = 3'd5;

	localparam logic [1:0] REG_WAVE_LEN   = 2'd0;
	localparam logic [1:0] REG_LOOP_LEN   = 2'd1;
	localparam logic [1:0] REG_ATTACK_LEN = 2'd2;
	localparam logic [1:0] REG_ENV_LEN    = 2'd3;

	// Per-voice state word kept in the voice memory.
	typedef struct packed {
		logic [15:0] step;
		logic [15:0] whole;
		logic [7:0]  frac;
		logic [7:0]  level;
		logic [7:0]  idx;
	} voice_t;

	localparam int VOICE_W = 56;
endpackage

/* hdl/pws_voice_ram.sv */
// Voice state memory: one read port, one write port, registered read.
// Depends on pws_pkg for the voice record.
`timescale 1ns / 1ps
module pws_voice_ram #(
	parameter int VOICES = 8,
	parameter int AW = 3
) (
	input  logic                 clk,
	input  logic [AW-1:0]        raddr,
	output pws_pkg::voice_t      rdata,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  pws_pkg::voice_t      wdata
);
	pws_pkg::voice_t mem [VOICES];

	// Synchronous write and read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/polyphonic_wavetable_synth.sv */
// Top level of the polyphonic wavetable synthesizer: sequencer, tables, mix.
// Depends on pws_pkg, pws_voice_ram and the assertion macro header.
//
// A command is taken when start is high and busy is low; its result appears
// on mix_out and voice_started with done high for one cycle, and the receiver
// cannot stall it. Loads and unused codes go straight to the done state. A note
// on reads the increment table, then writes the voice. Sample and envelope
// ticks walk the voice memory one voice at a time, each voice taking a read,
// then wave and envelope table reads, then scaling and write back; the next
// voice is not read until the one before it is written back. The voice
// memory holds no reset value: a clearing pass that writes every voice runs
// after reset, during which busy is high. Register writes are taken only while
// the block is idle, so cfg_ready follows busy.
`timescale 1ns / 1ps
`include "polyphonic_wavetable_synth_macros.svh"
module polyphonic_wavetable_synth #(
	parameter int VOICES = 8,
	parameter int WAVE_DEPTH = 2048,
	parameter int ENV_DEPTH = 256,
	parameter int NOTE_COUNT = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic [6:0]         note,
	input  logic [10:0]        load_addr,
	input  logic [15:0]        load_value,
	output logic               done,
	output logic signed [10:0] mix_out,
	output logic [2:0]         voice_started,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [10:0]        cfg_data
);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int WAW = $clog2(WAVE_DEPTH);
	localparam int EAW = $clog2(ENV_DEPTH);
	localparam int NAW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_NOTE1 = 4'd2;
	localparam logic [3:0] ST_NOTE2 = 4'd3;
	localparam logic [3:0] ST_RD    = 4'd4;
	localparam logic [3:0] ST_TBL   = 4'd5;
	localparam logic [3:0] ST_WB    = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;

	logic [3:0]  state_q;
	logic [VW-1:0] vix_q;
	logic [VW-1:0] next_voice_q;
	logic [2:0]  cmd_q;
	logic [6:0]  note_q;
	logic [10:0] wave_len_q, loop_len_q, attack_len_q;
	logic [8:0]  env_len_q;
	logic signed [15:0] sum_q;
	logic signed [10:0] last_mix_q;
	logic [2:0]  last_voice_q;
	logic        done_q;

	// Tables.
	logic [7:0]  wave_mem [WAVE_DEPTH];
	logic [7:0]  env_mem  [ENV_DEPTH];
	logic [15:0] step_mem [NOTE_COUNT];
	logic [7:0]  wave_rd_q, env_rd_q;
	logic [15:0] step_rd_q;

	// Voice memory.
	logic [VW-1:0]   v_raddr, v_waddr;
	logic            v_we;
	pws_pkg::voice_t v_rdata, v_wdata, cur_q;

	pws_voice_ram #(.VOICES(VOICES), .AW(VW)) u_ram (
		.clk(clk), .raddr(v_raddr), .rdata(v_rdata),
		.we(v_we), .waddr(v_waddr), .wdata(v_wdata)
	);

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign done = done_q;
	assign mix_out = last_mix_q;
	assign voice_started = last_voice_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_len_q <= '0;
			loop_len_q <= '0;
			attack_len_q <= '0;
			env_len_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pws_pkg::REG_WAVE_LEN:   wave_len_q <= cfg_data;
				pws_pkg::REG_LOOP_LEN:   loop_len_q <= cfg_data;
				pws_pkg::REG_ATTACK_LEN: attack_len_q <= cfg_data;
				pws_pkg::REG_ENV_LEN:    env_len_q <= {1'b0, cfg_data[7:0]} |
					(cfg_data[8] ? 9'h100 : 9'h000);
				default: ;
			endcase
		end
	end

	// Table writes and the registered table reads.
	logic [15:0] pos_idx;
	assign pos_idx = v_rdata.whole;
	always_ff @(posedge clk) begin
		if (accept && cmd == pws_pkg::CMD_LOAD_WAVE && 32'(load_addr) < WAVE_DEPTH) begin
			wave_mem[WAW'(load_addr)] <= load_value[7:0];
		end
		if (accept && cmd == pws_pkg::CMD_LOAD_ENV && 32'(load_addr) < ENV_DEPTH) begin
			env_mem[load_addr[EAW-1:0]] <= load_value[7:0];
		end
		if (accept && cmd == pws_pkg::CMD_LOAD_STEP && 32'(load_addr) < NOTE_COUNT) begin
			step_mem[load_addr[NAW-1:0]] <= load_value;
		end
		wave_rd_q <= wave_mem[pos_idx[WAW-1:0]];
		env_rd_q <= env_mem[v_rdata.idx[EAW-1:0]];
		step_rd_q <= step_mem[note_q[NAW-1:0]];
	end

	// Per-voice arithmetic on the voice read last cycle and its table data.
	logic        in_range;
	logic signed [8:0]  smp;
	logic signed [17:0] prod;
	logic signed [17:0] scaled;
	logic [15:0] mag;
	logic [16:0] mag_p1;
	logic [15:0] quo;
	logic [23:0] p;
	logic [15:0] whole_n;
	logic [8:0]  len_c;
	logic        adv;
	pws_pkg::voice_t upd;
	always_comb begin
		smp = in_range ? 9'(signed'(wave_rd_q)) : 9'sd0;
		prod = 18'(smp) * 18'(signed'({1'b0, cur_q.level}));
		// Divide the magnitude by 255 with a shift-and-add reciprocal, then
		// restore the sign so the quotient truncates toward zero.
		mag = prod[17] ? 16'(-prod) : 16'(prod);
		mag_p1 = 17'(mag) + 17'd1;
		quo = 16'((mag_p1 + (mag_p1 >> 8)) >> 8);
		scaled = prod[17] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
		p = 24'(cur_q.step) + 24'(cur_q.frac) + {cur_q.whole, 8'h00};
		whole_n = p[23:8];
		if (whole_n > 16'(wave_len_q)) begin
			whole_n = whole_n - 16'(loop_len_q);
		end
		len_c = (32'(env_len_q) > ENV_DEPTH) ? 9'(ENV_DEPTH) : env_len_q;
		adv = (cur_q.whole >= 16'(attack_len_q)) && (len_c >= 9'd1) &&
			(9'(cur_q.idx) + 9'd1 < len_c);
		upd = cur_q;
		if (cmd_q == pws_pkg::CMD_SAMPLE) begin
			upd.whole = whole_n;
			upd.frac = p[7:0];
		end else if (adv) begin
			upd.level = env_rd_q;
			upd.idx = cur_q.idx + 8'd1;
		end
	end

	logic in_range_q;
	assign in_range = in_range_q;

	// Voice memory port control.
	always_comb begin
		v_raddr = vix_q;
		v_we = 1'b0;
		v_waddr = vix_q;
		v_wdata = upd;
		case (state_q)
			ST_CLEAR: begin
				v_we = 1'b1;
				v_wdata = '{step: 16'd0, whole: 16'd0, frac: 8'd0, level: 8'hFF, idx: 8'd0};
			end
			ST_NOTE2: begin
				v_we = 1'b1;
				v_waddr = next_voice_q;
				v_wdata = '{step: (32'(note_q) < NOTE_COUNT) ? step_rd_q : 16'd0,
					whole: 16'd0, frac: 8'd0, level: 8'hFF, idx: 8'd0};
			end
			ST_WB: v_we = 1'b1;
			default: ;
		endcase
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			vix_q <= '0;
			next_voice_q <= '0;
			last_mix_q <= '0;
			last_voice_q <= '0;
			done_q <= 1'b0;
			cmd_q <= '0;
			note_q <= '0;
			sum_q <= '0;
			cur_q <= '0;
			in_range_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (32'(vix_q) == VOICES - 1) begin
						vix_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						vix_q <= vix_q + VW'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						note_q <= note;
						vix_q <= '0;
						sum_q <= '0;
						if (cmd == pws_pkg::CMD_NOTE_ON) begin
							state_q <= ST_NOTE1;
						end else if (cmd == pws_pkg::CMD_SAMPLE ||
							cmd == pws_pkg::CMD_ENV) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_NOTE1: state_q <= ST_NOTE2;
				ST_NOTE2: begin
					last_voice_q <= 3'(next_voice_q);
					if (32'(next_voice_q) == VOICES - 1) begin
						next_voice_q <= '0;
					end else begin
						next_voice_q <= next_voice_q + VW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_RD: state_q <= ST_TBL;
				ST_TBL: begin
					cur_q <= v_rdata;
					in_range_q <= 32'(v_rdata.whole) < WAVE_DEPTH;
					state_q <= ST_WB;
				end
				ST_WB: begin
					sum_q <= sum_q + 16'(scaled);
					if (32'(vix_q) == VOICES - 1) begin
						if (cmd_q == pws_pkg::CMD_SAMPLE) begin
							if (sum_q + 16'(scaled) > 16'sd1023) begin
								last_mix_q <= 11'sd1023;
							end else if (sum_q + 16'(scaled) < -16'sd1024) begin
								last_mix_q <= -11'sd1024;
							end else begin
								last_mix_q <= 11'(sum_q + 16'(scaled));
							end
						end
						state_q <= ST_DONE;
					end else begin
						vix_q <= vix_q + VW'(1);
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on the sequencer.
	`PWS_ASSERT_NEXT(a_done_idle, clk, arst_n, done_q, !done_q, "done held two cycles")
	`PWS_ASSERT_IMP(a_done_state, clk, arst_n, done_q, state_q == ST_IDLE, "done outside idle")
	`PWS_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accept did not set busy")
endmodule
